// File: sv/vrt_pkg.sv
// Shared types, codes and defaults for the voxel ray traversal block.
`default_nettype none
package vrt_pkg;

    localparam int CELL_COORD_BITS_DEF = 16;
    localparam int TIME_FRAC_SHIFT_DEF = 30;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [2:0] EAST  = 3'd0;
    localparam logic [2:0] WEST  = 3'd1;
    localparam logic [2:0] TOP   = 3'd2;
    localparam logic [2:0] BOT   = 3'd3;
    localparam logic [2:0] FRONT = 3'd4;
    localparam logic [2:0] BACK  = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [15:0] ip;
        logic        neg;
        logic [15:0] mag;
        logic [16:0] gap;
    } t_axis_setup;

    typedef struct packed {
        logic              op;
        logic              occupied;
        logic [7:0]        max_steps;
        t_axis_setup [2:0] ax;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        logic [2:0]  face;
    } t_result;

endpackage
`default_nettype wire

// File: sv/vrt_front.sv
// Input queue that splits each start item into per-axis setup values.
`default_nettype none
module vrt_front
    import vrt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic         i_operation,
    input  wire logic [31:0]  i_origin_x,
    input  wire logic [31:0]  i_origin_y,
    input  wire logic [31:0]  i_origin_z,
    input  wire logic [15:0]  i_dir_x,
    input  wire logic [15:0]  i_dir_y,
    input  wire logic [15:0]  i_dir_z,
    input  wire logic [7:0]   i_max_steps,
    input  wire logic         i_occupied,
    output logic              o_valid,
    output t_item             o_item,
    input  wire logic         i_take
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_item      w_item;
    logic       w_wr;
    logic       w_rd;

    function automatic t_axis_setup f_setup(input logic [31:0] o, input logic [15:0] d);
        t_axis_setup s;
        s.ip   = o[31:16];
        s.neg  = d[15];
        s.mag  = d[15] ? 16'(17'h10000 - {1'b0, d}) : d;
        if (d[15]) begin
            s.gap = {1'b0, o[15:0]};
        end else if (o[15:0] == 16'd0) begin
            s.gap = 17'd0;
        end else begin
            s.gap = 17'h10000 - {1'b0, o[15:0]};
        end
        return s;
    endfunction

    always_comb begin
        w_item.op        = i_operation;
        w_item.occupied  = i_occupied;
        w_item.max_steps = i_max_steps;
        w_item.ax[0]     = f_setup(i_origin_x, i_dir_x);
        w_item.ax[1]     = f_setup(i_origin_y, i_dir_y);
        w_item.ax[2]     = f_setup(i_origin_z, i_dir_z);
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = push && !full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule
`default_nettype wire

// File: sv/vrt_div.sv
// Bit-serial restoring divider for the crossing times.
`default_nettype none
module vrt_div #(
    parameter int DW = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [15:0]   i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [15:0]   r_rem;
    logic [DW-1:0] r_quot;
    logic [15:0]   r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [16:0]   w_sh;
    logic          w_ge;

    assign w_sh   = {r_rem, r_quot[DW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? 16'(w_sh - {1'b0, r_div}) : w_sh[15:0];
            r_quot <= {r_quot[DW-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

// File: sv/vrt_walk.sv
// Walk engine: ray setup through the divider, DDA steps and the result register.
`default_nettype none
module vrt_walk
    import vrt_pkg::*;
#(
    parameter int CELL_COORD_BITS = CELL_COORD_BITS_DEF,
    parameter int TIME_FRAC_SHIFT = TIME_FRAC_SHIFT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  t_item      i_item,
    output logic       o_take,
    output logic       empty,
    input  wire logic  pop,
    output t_result    o_res
);

    localparam int CB = CELL_COORD_BITS;
    localparam int DW = TIME_FRAC_SHIFT + 1;

    typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_WAIT} t_state;
    typedef enum logic [1:0] {W_IDLE, W_ORIGIN, W_STEP} t_walk;

    t_state        r_state, n_state;
    t_walk         r_walk, n_walk;
    logic [1:0]    r_axis, n_axis;
    logic          r_phase, n_phase;
    logic [47:0]   r_next [3];
    logic [47:0]   n_next [3];
    logic [31:0]   r_cstep [3];
    logic [31:0]   n_cstep [3];
    logic [CB-1:0] r_cell [3];
    logic [CB-1:0] n_cell [3];
    logic [15:0]   r_mag [3];
    logic [15:0]   n_mag [3];
    logic [16:0]   r_dist [3];
    logic [16:0]   n_dist [3];
    logic [2:0]    r_neg, n_neg;
    logic [2:0]    r_mov, n_mov;
    logic [1:0]    r_last, n_last;
    logic [8:0]    r_steps, n_steps;
    logic [7:0]    r_limit, n_limit;
    logic          r_out_valid, n_out_valid;
    t_result       r_res, n_res;

    logic          w_slot;
    logic          w_start;
    logic [DW-1:0] w_dividend;
    logic          w_done;
    logic [DW-1:0] w_quot;
    logic [47:0]   w_q48;
    logic          w_selx, w_sely;
    logic [1:0]    w_best;
    logic [2:0]    w_face;

    vrt_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_mag[r_axis]),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    assign w_slot = !r_out_valid || pop;
    assign o_take = (r_state == S_IDLE) && i_valid && w_slot;
    assign empty  = !r_out_valid;
    assign o_res  = r_res;
    assign w_q48  = 48'(w_quot);

    assign w_start    = (r_state == S_LAUNCH) && r_mov[r_axis];
    assign w_dividend = r_phase ? (DW'(r_dist[r_axis]) << (TIME_FRAC_SHIFT - 16))
                                : (DW'(1) << TIME_FRAC_SHIFT);

    always_comb begin
        w_selx = r_mov[0] && (!r_mov[1] || r_next[0] <= r_next[1])
                          && (!r_mov[2] || r_next[0] <= r_next[2]);
        w_sely = !w_selx && r_mov[1] && (!r_mov[0] || r_next[1] < r_next[0])
                                     && (!r_mov[2] || r_next[1] <= r_next[2]);
        w_best = w_selx ? AXIS_X : (w_sely ? AXIS_Y : AXIS_Z);
    end

    always_comb begin
        unique case (r_last)
            AXIS_X:  w_face = r_neg[0] ? WEST : EAST;
            AXIS_Y:  w_face = r_neg[1] ? TOP : BOT;
            default: w_face = r_neg[2] ? BACK : FRONT;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_axis      = r_axis;
        n_phase     = r_phase;
        n_next      = r_next;
        n_cstep     = r_cstep;
        n_cell      = r_cell;
        n_mag       = r_mag;
        n_dist      = r_dist;
        n_neg       = r_neg;
        n_mov       = r_mov;
        n_last      = r_last;
        n_steps     = r_steps;
        n_limit     = r_limit;
        n_out_valid = r_out_valid && !pop;
        n_res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (o_take) begin
                    n_out_valid = 1'b1;
                    n_res       = '0;
                    if (i_item.op == OP_START) begin
                        for (int a = 0; a < 3; a++) begin
                            n_cell[a] = CB'($signed(i_item.ax[a].ip));
                            n_mag[a]  = i_item.ax[a].mag;
                            n_dist[a] = i_item.ax[a].gap;
                            n_neg[a]  = i_item.ax[a].neg;
                            n_mov[a]  = (i_item.ax[a].mag != 16'd0);
                        end
                        n_last     = AXIS_Y;
                        n_steps    = 9'd0;
                        n_limit    = i_item.max_steps;
                        n_walk     = W_ORIGIN;
                        n_axis     = AXIS_X;
                        n_phase    = 1'b0;
                        n_state    = S_LAUNCH;
                        n_res.kind = KIND_QUERY;
                        n_res.vx   = 16'($signed(n_cell[0]));
                        n_res.vy   = 16'($signed(n_cell[1]));
                        n_res.vz   = 16'($signed(n_cell[2]));
                    end else if (r_walk == W_IDLE) begin
                        n_res.kind = KIND_MISS;
                    end else if (i_item.occupied) begin
                        n_walk     = W_IDLE;
                        n_res.kind = KIND_HIT;
                        n_res.face = (r_walk == W_ORIGIN) ? TOP : w_face;
                        n_res.vx   = 16'($signed(r_cell[0]));
                        n_res.vy   = 16'($signed(r_cell[1]));
                        n_res.vz   = 16'($signed(r_cell[2]));
                    end else if (r_steps <= {1'b0, r_limit} && (r_mov != 3'd0)) begin
                        n_next[w_best] = r_next[w_best] + 48'(r_cstep[w_best]);
                        n_cell[w_best] = r_neg[w_best] ? r_cell[w_best] - CB'(1)
                                                       : r_cell[w_best] + CB'(1);
                        n_last     = w_best;
                        n_steps    = r_steps + 9'd1;
                        n_walk     = W_STEP;
                        n_res.kind = KIND_QUERY;
                        n_res.vx   = 16'($signed(n_cell[0]));
                        n_res.vy   = 16'($signed(n_cell[1]));
                        n_res.vz   = 16'($signed(n_cell[2]));
                    end else begin
                        n_walk     = W_IDLE;
                        n_res.kind = KIND_MISS;
                    end
                end
            end
            S_LAUNCH: begin
                if (r_mov[r_axis]) begin
                    n_state = S_WAIT;
                end else begin
                    n_next[r_axis]  = '1;
                    n_cstep[r_axis] = '0;
                    n_phase         = 1'b0;
                    n_axis          = r_axis + 2'd1;
                    if (r_axis == AXIS_Z) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    if (r_phase) begin
                        n_next[r_axis] = w_q48;
                        n_phase        = 1'b0;
                        n_axis         = r_axis + 2'd1;
                        n_state        = (r_axis == AXIS_Z) ? S_IDLE : S_LAUNCH;
                    end else begin
                        n_cstep[r_axis] = (w_q48 > 48'hFFFF_FFFF) ? '1 : w_q48[31:0];
                        n_phase         = 1'b1;
                        n_state         = S_LAUNCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_walk      <= W_IDLE;
            r_axis      <= AXIS_X;
            r_phase     <= 1'b0;
            r_neg       <= '0;
            r_mov       <= '0;
            r_last      <= AXIS_Y;
            r_steps     <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_next[a]  <= '0;
                r_cstep[a] <= '0;
                r_cell[a]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_axis      <= n_axis;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_mov       <= n_mov;
            r_last      <= n_last;
            r_steps     <= n_steps;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
            r_next      <= n_next;
            r_cstep     <= n_cstep;
            r_cell      <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_dist <= n_dist;
        r_res  <= n_res;
    end

endmodule
`default_nettype wire

// File: sv/voxel_ray_traversal.sv
// Top level of the voxel ray traversal block.
// A start item is answered with a query of the origin voxel; the walk then
// sets up its crossing times with one shared bit-serial divider, six
// divisions for a ray that moves on all three axes, and takes no new
// item until that setup is done. Each occupancy answer gives a query, a
// hit or a miss. A two-entry input queue and a one-entry result register let
// either side stall on its own.
`default_nettype none
module voxel_ray_traversal
    import vrt_pkg::*;
#(
    parameter int CELL_COORD_BITS = CELL_COORD_BITS_DEF,
    parameter int TIME_FRAC_SHIFT = TIME_FRAC_SHIFT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_origin_x,
    input  wire logic [31:0] i_origin_y,
    input  wire logic [31:0] i_origin_z,
    input  wire logic [15:0] i_dir_x,
    input  wire logic [15:0] i_dir_y,
    input  wire logic [15:0] i_dir_z,
    input  wire logic [7:0]  i_max_steps,
    input  wire logic        i_occupied,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_voxel_x,
    output logic [15:0]      o_voxel_y,
    output logic [15:0]      o_voxel_z,
    output logic [2:0]       o_face
);

    logic    w_valid;
    logic    w_take;
    t_item   w_item;
    t_result w_res;

    vrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_origin_z  (i_origin_z),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .i_max_steps (i_max_steps),
        .i_occupied  (i_occupied),
        .o_valid     (w_valid),
        .o_item      (w_item),
        .i_take      (w_take)
    );

    vrt_walk #(
        .CELL_COORD_BITS (CELL_COORD_BITS),
        .TIME_FRAC_SHIFT (TIME_FRAC_SHIFT)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_res)
    );

    assign o_kind    = w_res.kind;
    assign o_voxel_x = w_res.vx;
    assign o_voxel_y = w_res.vy;
    assign o_voxel_z = w_res.vz;
    assign o_face    = w_res.face;

endmodule
`default_nettype wire
